/* hw/rtl/hrrd_pkg.sv */
// Shared types, codes and character constants for the HTTP request ready detector.
package hrrd_pkg;

    // Operation codes carried with each input word.
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_CLOSE = 2'd1;
    localparam logic [1:0] OP_NEW   = 2'd2;

    // Decision codes reported on the status output.
    localparam logic [1:0] ST_PENDING  = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;
    localparam logic [1:0] ST_FORCED   = 2'd3;

    // Characters of interest.
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_G  = 8'h47;
    localparam logic [7:0] CH_H  = 8'h48;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_1  = 8'h31;

    // One input word as held in the input register.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
    } t_item;

    // Expected character after 'G' in "GET ".
    function automatic logic [7:0] get_tail(input logic [1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            2'd0:    ch = 8'h45;   // 'E'
            2'd1:    ch = 8'h54;   // 'T'
            default: ch = CH_SP;
        endcase
        return ch;
    endfunction

    // Expected character after 'H' in "HEAD ".
    function automatic logic [7:0] head_tail(input logic [1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            2'd0:    ch = 8'h45;   // 'E'
            2'd1:    ch = 8'h41;   // 'A'
            2'd2:    ch = 8'h44;   // 'D'
            default: ch = CH_SP;
        endcase
        return ch;
    endfunction

    // Expected character of the version prefix "HTTP/1.".
    function automatic logic [7:0] vers_prefix(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h48;   // 'H'
            3'd1:    ch = 8'h54;   // 'T'
            3'd2:    ch = 8'h54;   // 'T'
            3'd3:    ch = 8'h50;   // 'P'
            3'd4:    ch = 8'h2F;   // '/'
            3'd5:    ch = 8'h31;   // '1'
            default: ch = 8'h2E;   // '.'
        endcase
        return ch;
    endfunction

endpackage

/* hw/rtl/hrrd_in_stage.sv */
// Input register stage: holds one accepted word until the core takes it.
module hrrd_in_stage
    import hrrd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // The register frees up whenever it is empty or its word is taken this cycle.
    assign o_ready = !r_valid || i_take;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload capture.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* hw/rtl/hrrd_core.sv */
// Request parser state, per-word judgment and the result register.
module hrrd_core
    import hrrd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  t_item      i_item,
    input  logic       i_version_check_enable,
    input  logic       i_out_take,
    output logic       o_valid,
    output logic [1:0] o_status
);

    typedef enum logic [2:0] {
        PH_METHOD_FIRST = 3'd0,
        PH_METHOD_REST  = 3'd1,
        PH_LINE_SCAN    = 3'd2,
        PH_VERSION      = 3'd3,
        PH_HEADERS      = 3'd4
    } t_phase;

    t_phase      r_phase,     n_phase;
    logic        r_is_head,   n_is_head;
    logic [2:0]  r_pos,       n_pos;
    logic [1:0]  r_runs,      n_runs;
    logic        r_in_run,    n_in_run;
    logic [23:0] r_last3,     n_last3;
    logic [1:0]  r_decision,  n_decision;
    logic        r_out_valid;

    // Next-state logic for one word.
    always_comb begin
        logic [7:0] b;
        logic [2:0] len;
        logic [2:0] pos_inc;
        logic [7:0] want;
        logic       method_end;

        b          = i_item.data_byte;
        len        = r_is_head ? 3'd4 : 3'd3;
        pos_inc    = r_pos + 3'd1;
        want       = r_is_head ? head_tail(r_pos[1:0])
                               : get_tail((r_pos < 3'd3) ? r_pos[1:0] : 2'd2);
        method_end = 1'b0;

        n_phase    = r_phase;
        n_is_head  = r_is_head;
        n_pos      = r_pos;
        n_runs     = r_runs;
        n_in_run   = r_in_run;
        n_last3    = r_last3;
        n_decision = r_decision;

        if (i_fire) begin
            if (i_item.op == OP_NEW) begin
                n_phase    = PH_METHOD_FIRST;
                n_is_head  = 1'b0;
                n_pos      = 3'd0;
                n_runs     = 2'd0;
                n_in_run   = 1'b0;
                n_last3    = 24'd0;
                n_decision = ST_PENDING;
            end else if (i_item.op == OP_CLOSE) begin
                if (r_decision == ST_PENDING) begin
                    n_decision = ST_FORCED;
                end
            end else if (i_item.op == OP_BYTE && r_decision == ST_PENDING) begin
                n_last3 = {r_last3[15:0], b};
                unique case (r_phase)
                    PH_METHOD_FIRST: begin
                        if (b == CH_G || b == CH_H) begin
                            n_is_head = (b == CH_H);
                            n_pos     = 3'd0;
                            n_phase   = PH_METHOD_REST;
                        end else begin
                            n_decision = ST_MISMATCH;
                        end
                    end
                    PH_METHOD_REST: begin
                        if (r_pos >= len) begin
                            method_end = 1'b1;
                        end else if (b != want) begin
                            n_decision = ST_MISMATCH;
                        end else if (pos_inc >= len) begin
                            method_end = 1'b1;
                        end else begin
                            n_pos = pos_inc;
                        end
                    end
                    PH_LINE_SCAN: begin
                        if (b == CH_SP) begin
                            if (!r_in_run) begin
                                if (r_runs != 2'd3) begin
                                    n_runs = r_runs + 2'd1;
                                end
                                n_in_run = 1'b1;
                            end
                        end else if (b == CH_CR || b == CH_LF) begin
                            n_decision = ST_MISMATCH;
                        end else if (r_runs >= 2'd2) begin
                            if (b == vers_prefix(3'd0)) begin
                                n_phase = PH_VERSION;
                                n_pos   = 3'd1;
                            end else begin
                                n_decision = ST_MISMATCH;
                            end
                        end else begin
                            n_in_run = 1'b0;
                        end
                    end
                    PH_VERSION: begin
                        if (r_pos != 3'd7) begin
                            if (b != vers_prefix(r_pos)) begin
                                n_decision = ST_MISMATCH;
                            end else begin
                                n_pos = pos_inc;
                            end
                        end else if (b == CH_0 || b == CH_1) begin
                            n_phase = PH_HEADERS;
                            n_pos   = 3'd0;
                        end else begin
                            n_decision = ST_MISMATCH;
                        end
                    end
                    default: begin
                        // End of headers: LF LF or LF CR LF at the tail.
                        if (n_last3[7:0] == CH_LF &&
                            (n_last3[15:8] == CH_LF ||
                             (n_last3[15:8] == CH_CR && n_last3[23:16] == CH_LF))) begin
                            n_decision = ST_COMPLETE;
                        end
                    end
                endcase

                // Method matched: either scan the request line or wait for headers.
                if (method_end) begin
                    n_pos = 3'd0;
                    if (i_version_check_enable) begin
                        n_phase  = PH_LINE_SCAN;
                        n_runs   = 2'd1;
                        n_in_run = 1'b1;
                    end else begin
                        n_phase = PH_HEADERS;
                    end
                end
            end
        end
    end

    // Parser state and decision; the decision register is the result payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_METHOD_FIRST;
            r_is_head  <= 1'b0;
            r_pos      <= 3'd0;
            r_runs     <= 2'd0;
            r_in_run   <= 1'b0;
            r_last3    <= 24'd0;
            r_decision <= ST_PENDING;
        end else begin
            r_phase    <= n_phase;
            r_is_head  <= n_is_head;
            r_pos      <= n_pos;
            r_runs     <= n_runs;
            r_in_run   <= n_in_run;
            r_last3    <= n_last3;
            r_decision <= n_decision;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_decision;

endmodule

/* hw/rtl/http_request_ready_detector.sv */
// Top level of the HTTP request ready detector: handshakes, register and checks.
//
// Each input word carries one received byte, a buffer closed or full event, or a
// new-connection marker, and produces exactly one status word. A word passes
// through the input register and then the parser logic into the result register,
// from which its status word is offered. One word per cycle is sustained whenever
// the result side keeps up. The version check enable register is sampled when the
// method completes and resets to 1.
module http_request_ready_detector
    import hrrd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_op,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_status,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata
);

    logic  r_version_check_enable;
    t_item w_in_item;
    t_item w_held_item;
    logic  w_held_valid;
    logic  w_out_valid;
    logic  w_fire;

    assign w_in_item.op        = i_op;
    assign w_in_item.data_byte = i_data_byte;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version_check_enable <= 1'b1;
        end else if (i_cfg_we) begin
            r_version_check_enable <= i_cfg_wdata;
        end
    end

    // The core takes a held word when the result register is free or being emptied.
    assign w_fire = w_held_valid && (!w_out_valid || i_ready);

    hrrd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (w_in_item),
        .i_take  (w_fire),
        .o_ready (o_ready),
        .o_valid (w_held_valid),
        .o_item  (w_held_item)
    );

    hrrd_core u_core (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_fire                 (w_fire),
        .i_item                 (w_held_item),
        .i_version_check_enable (r_version_check_enable),
        .i_out_take             (i_ready),
        .o_valid                (w_out_valid),
        .o_status               (o_status)
    );

    assign o_valid = w_out_valid;

    // A new connection always reports pending.
    a_new_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_held_item.op == OP_NEW) |=> (o_valid && o_status == ST_PENDING))
        else $error("new connection did not report pending");

    // Closed or full while pending forces delivery.
    a_close_forces: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_held_item.op == OP_CLOSE && o_status == ST_PENDING)
        |=> (o_status == ST_FORCED))
        else $error("closed or full event did not force delivery");

    // A made decision holds for everything but a new connection.
    a_decision_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_held_item.op != OP_NEW && o_status != ST_PENDING) |=> $stable(o_status))
        else $error("decision changed without a new connection");

    // Back pressure on the input only while a word is held.
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> w_held_valid)
        else $error("input stalled with an empty input register");

endmodule

/* bench/http_request_ready_detector_tb.sv */
// Self-checking testbench for the HTTP request ready detector: directed and random words.
`timescale 1ns / 1ps

module http_request_ready_detector_tb
    import hrrd_pkg::*;
;

    // Op code that the block must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Text that the parser matches against.
    localparam logic [23:0] GET_TAIL    = "ET ";
    localparam logic [31:0] HEAD_TAIL   = "EAD ";
    localparam logic [55:0] VERS_PREFIX = "HTTP/1.";

    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [2:0] {
        PS_METHOD_FIRST,
        PS_METHOD_REST,
        PS_LINE_SCAN,
        PS_VERSION,
        PS_HEADERS
    } t_parse_phase;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [1:0] i_op = OP_BYTE;
    logic [7:0] i_data_byte = 8'h00;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [1:0] o_status;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_wdata = 1'b0;

    // Words waiting to be sent, statuses waiting to come back.
    t_item      pending_words[$];
    logic [1:0] due_status[$];
    logic [7:0] draft[$];

    int n_queued = 0;
    int n_fail = 0;
    int cycles = 0;
    int send_gap = 0;
    int stall_left = 0;
    bit idle_on = 1'b0;

    // Predicted parser state and register copy.
    logic         p_vc;
    t_parse_phase p_phase;
    logic         p_head;
    logic [2:0]   p_pos;
    logic [1:0]   p_sruns;
    logic         p_in_run;
    logic [23:0]  p_hist;
    logic [1:0]   p_dec;

    http_request_ready_detector u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // A new connection returns every parser entry to its reset value.
    task automatic clear_parser();
        p_phase  = PS_METHOD_FIRST;
        p_head   = 1'b0;
        p_pos    = 3'd0;
        p_sruns  = 2'd0;
        p_in_run = 1'b0;
        p_hist   = 24'h0;
        p_dec    = ST_PENDING;
    endtask

    // The method's own space counts as the first space run when versions are checked.
    task automatic finish_method();
        if (p_vc) begin
            p_phase  = PS_LINE_SCAN;
            p_sruns  = 2'd1;
            p_in_run = 1'b1;
        end else begin
            p_phase = PS_HEADERS;
        end
        p_pos = 3'd0;
    endtask

    // Advance the predicted parser by one word and give the status it should report.
    task automatic advance_parser(input logic [1:0] op, input logic [7:0] b,
                                  output logic [1:0] st);
        logic [2:0] len;
        logic [2:0] pos;
        logic [7:0] want;
        if (op == OP_NEW) begin
            clear_parser();
        end else if (op == OP_CLOSE) begin
            if (p_dec == ST_PENDING) p_dec = ST_FORCED;
        end else if (op == OP_BYTE && p_dec == ST_PENDING) begin
            p_hist = {p_hist[15:0], b};
            case (p_phase)
                PS_METHOD_FIRST: begin
                    if (b == CH_G || b == CH_H) begin
                        p_head  = (b == CH_H);
                        p_pos   = 3'd0;
                        p_phase = PS_METHOD_REST;
                    end else begin
                        p_dec = ST_MISMATCH;
                    end
                end
                PS_METHOD_REST: begin
                    len = p_head ? 3'd4 : 3'd3;
                    pos = p_pos;
                    if (pos >= len) begin
                        finish_method();
                    end else begin
                        want = p_head ? HEAD_TAIL[8*(3-pos) +: 8] : GET_TAIL[8*(2-pos) +: 8];
                        if (b != want) p_dec = ST_MISMATCH;
                        else if (pos + 1 >= len) finish_method();
                        else p_pos = pos + 3'd1;
                    end
                end
                PS_LINE_SCAN: begin
                    if (b == CH_SP) begin
                        if (!p_in_run) begin
                            if (p_sruns < 2'd3) p_sruns = p_sruns + 2'd1;
                            p_in_run = 1'b1;
                        end
                    end else if (b == CH_CR || b == CH_LF) begin
                        p_dec = ST_MISMATCH;
                    end else if (p_sruns >= 2'd2) begin
                        // The version token must start right after the second space run.
                        if (b == VERS_PREFIX[55:48]) begin
                            p_phase = PS_VERSION;
                            p_pos   = 3'd1;
                        end else begin
                            p_dec = ST_MISMATCH;
                        end
                    end else begin
                        p_in_run = 1'b0;
                    end
                end
                PS_VERSION: begin
                    if (p_pos < 3'd7) begin
                        if (b != VERS_PREFIX[8*(6-p_pos) +: 8]) p_dec = ST_MISMATCH;
                        else p_pos = p_pos + 3'd1;
                    end else if (b == CH_0 || b == CH_1) begin
                        p_phase = PS_HEADERS;
                        p_pos   = 3'd0;
                    end else begin
                        p_dec = ST_MISMATCH;
                    end
                end
                default: begin
                    // End of headers: LF LF or LF CR LF.
                    if (p_hist[7:0] == CH_LF && (p_hist[15:8] == CH_LF ||
                        (p_hist[15:8] == CH_CR && p_hist[23:16] == CH_LF)))
                        p_dec = ST_COMPLETE;
                end
            endcase
        end
        st = p_dec;
    endtask

    task automatic put(input logic [1:0] op, input logic [7:0] b);
        t_item w;
        w.op        = op;
        w.data_byte = b;
        pending_words.push_back(w);
        n_queued++;
    endtask

    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++) put(OP_BYTE, s[k]);
    endtask

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++) draft.push_back(s[k]);
    endtask

    task automatic add_eol();
        if ($urandom_range(0, 1)) add_text("\r\n");
        else add_text("\n");
    endtask

    function automatic logic [7:0] token_char();
        return 8'($urandom_range(8'h21, 8'h7E));
    endfunction

    // Queue one connection: mostly a plausible request, sometimes damaged or pure noise.
    task automatic queue_request();
        int n;
        int bad;
        int cut;
        int shut;
        draft.delete();
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 24);
            repeat (n) draft.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 1)) add_text("GET ");
            else add_text("HEAD ");
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++)
                draft.push_back(($urandom_range(0, 11) == 0) ? CH_SP : token_char());
            repeat ($urandom_range(1, 3)) draft.push_back(CH_SP);
            case ($urandom_range(0, 9))
                0: ;    // old-style request line without a version
                1: add_text("HTTP/1.2");
                2: add_text("HTTP/2.0");
                default: add_text($urandom_range(0, 1) ? "HTTP/1.1" : "HTTP/1.0");
            endcase
            add_eol();
            repeat ($urandom_range(0, 3)) begin
                n = $urandom_range(1, 6);
                repeat (n) draft.push_back(token_char());
                add_text(": ");
                n = $urandom_range(0, 8);
                repeat (n) draft.push_back(token_char());
                add_eol();
            end
            add_eol();
        end

        // Damage: one wrong byte, an early cut, an early close, stray unused ops.
        bad  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, draft.size() - 1) : -1;
        cut  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, draft.size() - 1) : draft.size();
        shut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, cut) : -1;
        put(OP_NEW, 8'($urandom_range(0, 255)));
        for (int k = 0; k < cut; k++) begin
            if (k == shut) put(OP_CLOSE, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 39) == 0) put(OP_UNUSED, 8'($urandom_range(0, 255)));
            put(OP_BYTE, (k == bad) ? 8'($urandom_range(0, 255)) : draft[k]);
        end
        if (shut == cut || $urandom_range(0, 3) == 0) put(OP_CLOSE, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2)) put(OP_BYTE, 8'($urandom_range(0, 255)));
    endtask

    // Wait until every queued word has been sent and every status has come back.
    task automatic drain();
        do @(posedge i_clk);
        while (pending_words.size() != 0 || i_valid || due_status.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_version_check(input logic v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        p_vc = v;
    endtask

    // Sender: predicts each accepted word and presents the next one, with random gaps.
    always @(posedge i_clk) begin : send_words
        logic [1:0] st;
        t_item      w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                advance_parser(i_op, i_data_byte, st);
                due_status.push_back(st);
            end
            if (!(i_valid && !o_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    w = pending_words.pop_front();
                    i_op        <= w.op;
                    i_data_byte <= w.data_byte;
                    i_valid     <= 1'b1;
                    if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 14);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each status word against the oldest prediction, with random stalls.
    always @(posedge i_clk) begin : check_status
        logic [1:0] want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (due_status.size() == 0) begin
                    $display("%0t: status word with none expected: expected none, actual %0d",
                             $time, o_status);
                    n_fail++;
                end else begin
                    want = due_status.pop_front();
                    if (o_status !== want) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want, o_status);
                        n_fail++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 14);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Test sequence.
    initial begin : run_phases
        p_vc = 1'b1;
        clear_parser();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;

        // Version check on from reset: bad first byte, repeats after a decision,
        // a line break before the version, close while pending, and a wrong version start.
        put(OP_BYTE, "X");
        put(OP_BYTE, 8'hFF);
        put(OP_CLOSE, 8'h00);
        put(OP_UNUSED, 8'hFF);
        put(OP_NEW, 8'h00);
        put_text("GET ");
        put(OP_BYTE, CH_CR);
        put(OP_NEW, 8'hFF);
        put(OP_CLOSE, 8'hFF);
        put(OP_NEW, 8'h00);
        put_text("HEAD  / x");
        drain();

        // Version check off: both header endings straight after the method.
        write_version_check(1'b0);
        put(OP_NEW, 8'h00);
        put_text("GET \n\n");
        put(OP_NEW, 8'h00);
        put_text("HEAD \n\r\n");
        while (n_queued < 550) queue_request();
        drain();

        // Version check on, no idling on either side.
        idle_on = 1'b0;
        write_version_check(1'b1);
        while (n_queued < 1000) queue_request();
        drain();

        idle_on = 1'b1;
        write_version_check(1'($urandom_range(0, 1)));
        while (n_queued < 1450) queue_request();
        drain();

        // Closing stretch at full rate.
        idle_on = 1'b0;
        write_version_check(1'b1);
        while (n_queued < 1900) queue_request();
        drain();

        repeat (8) @(posedge i_clk);
        if (n_fail == 0 && due_status.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
